>>> hdl/dmf_pkg.sv
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared sizes, codes and types of the max-flow / min-cut engine.
// ----------------------------------------------------------------------------
package dmf_pkg;

   localparam int MAX_NODES      = 64;
   localparam int MAX_EDGES      = 256;
   localparam int CAPACITY_WIDTH = 16;

   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int NCNT_W     = NODE_W + 1;
   localparam int LEVEL_W    = NODE_W + 1;
   localparam int ARC_DEPTH  = 2 * MAX_EDGES;
   localparam int ARC_W      = $clog2(ARC_DEPTH);
   localparam int PTR_W      = ARC_W + 1;
   localparam int ECNT_W     = $clog2(MAX_EDGES + 1);
   localparam int SUM_W      = 24;
   localparam int CUTN_W     = 9;

   localparam logic [PTR_W-1:0] ARC_NONE = {PTR_W{1'b1}};

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_OVF   = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;
   localparam logic [1:0] STAT_SAME  = 2'd3;

   // register indexes
   localparam logic [1:0] REG_NODE_COUNT = 2'd0;
   localparam logic [1:0] REG_SOURCE     = 2'd1;
   localparam logic [1:0] REG_SINK       = 2'd2;

   localparam int STATE_W = 29;

   typedef enum logic [STATE_W-1:0] {
      ST_IDLE    = 29'h1 << 0,
      ST_LD1     = 29'h1 << 1,
      ST_LD2     = 29'h1 << 2,
      ST_SOLVE   = 29'h1 << 3,
      ST_B_INIT  = 29'h1 << 4,
      ST_B_POP   = 29'h1 << 5,
      ST_B_U     = 29'h1 << 6,
      ST_B_UH    = 29'h1 << 7,
      ST_B_ARC   = 29'h1 << 8,
      ST_I_SWEEP = 29'h1 << 9,
      ST_D_TOP   = 29'h1 << 10,
      ST_D_CUR   = 29'h1 << 11,
      ST_D_ARC   = 29'h1 << 12,
      ST_D_LV    = 29'h1 << 13,
      ST_D_RET   = 29'h1 << 14,
      ST_D_POP   = 29'h1 << 15,
      ST_D_POP2  = 29'h1 << 16,
      ST_A_RS    = 29'h1 << 17,
      ST_A_RR    = 29'h1 << 18,
      ST_A_RC    = 29'h1 << 19,
      ST_S_RS    = 29'h1 << 20,
      ST_S_R1    = 29'h1 << 21,
      ST_S_R2    = 29'h1 << 22,
      ST_S_R3    = 29'h1 << 23,
      ST_C_R0    = 29'h1 << 24,
      ST_C_R1    = 29'h1 << 25,
      ST_C_R2    = 29'h1 << 26,
      ST_OUT     = 29'h1 << 27,
      ST_SPARE   = 29'h1 << 28
   } state_type;

endpackage

>>> hdl/dmf_ram.sv
// ----------------------------------------------------------------------------
// dmf_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> hdl/dinic_max_flow_min_cut.sv
// ----------------------------------------------------------------------------
// dinic_max_flow_min_cut
// Edge loader and Dinic max-flow / min-cut solver over arc memories.
// ----------------------------------------------------------------------------
// Edges arrive one per req transfer and are linked into per-node arc lists
// held in on-chip RAMs; a stored edge takes two read-modify-write steps on
// the list-head memory, while a dropped edge writes nothing. The transfer
// with tlast set starts the solve: repeated level passes and depth-first
// augmentation with a path stack, then a scan of the stored edges for the
// cut. The solve runs on a single sequencer that touches one arc entry per
// step, so its length grows with arcs visited; each phase that reaches the
// sink adds a sweep that loads the current-arc pointers. One rsp transfer
// then carries the result and the graph is cleared at once; a finished
// result may wait in the output register while the next graph loads. No
// input is taken during a solve.
// ----------------------------------------------------------------------------
module dinic_max_flow_min_cut
   import dmf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // tdata: from_node[5:0], to_node[11:6], capacity[27:12], zero pad
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic         req_tlast,     // last_edge
   // tdata: max_flow[23:0], cut_capacity[47:24], source_side_mask[111:48],
   //        cut_edge_count[120:112], status[122:121], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // configuration
   logic [NCNT_W-1:0] node_count_ff, node_count_in;
   logic [NODE_W-1:0] src_ff, src_in, snk_ff, snk_in;

   // control
   state_type         state_ff, state_in;
   logic [ECNT_W-1:0] edge_count_ff, edge_count_in;
   logic [SUM_W-1:0]  flow_ff, flow_in;
   logic [1:0]        ls_ff, ls_in;
   logic [MAX_NODES-1:0] hv_ff, hv_in;
   logic              hv_rd_ff, hv_rd_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [NODE_W-1:0] from_ff, from_in, to_ff, to_in;
   logic [CAPACITY_WIDTH-1:0] cap_ff, cap_in;
   logic              last_ff, last_in;
   logic [1:0]        status_ff, status_in;
   logic [MAX_NODES-1:0] reached_ff, reached_in;
   logic [NCNT_W-1:0] qh_ff, qh_in, qt_ff, qt_in;
   logic [NODE_W-1:0] u_ff, u_in, v_ff, v_in;
   logic [LEVEL_W-1:0] lvl_u_ff, lvl_u_in;
   logic [PTR_W-1:0]  a_ff, a_in, n_ff, n_in;
   logic [CAPACITY_WIDTH-1:0] r_ff, r_in, b_ff, b_in, r0_ff, r0_in;
   logic [NCNT_W-1:0] depth_ff, depth_in, k_ff, k_in, sw_ff, sw_in;
   logic [ARC_W-1:0]  p_ff, p_in;
   logic [ECNT_W-1:0] e_ff, e_in;
   logic [NODE_W-1:0] ehead_ff, ehead_in;
   logic [SUM_W-1:0]  cut_sum_ff, cut_sum_in;
   logic [CUTN_W-1:0] cut_n_ff, cut_n_in;

   // output payload
   logic [SUM_W-1:0]  o_flow_ff, o_flow_in, o_cut_ff, o_cut_in;
   logic [MAX_NODES-1:0] o_mask_ff, o_mask_in;
   logic [CUTN_W-1:0] o_cnt_ff, o_cnt_in;
   logic [1:0]        o_stat_ff, o_stat_in;

   // RAM ports
   logic              tgt_we, res_we, nxt_we, hd_we, lvl_we, cur_we, que_we, stk_we;
   logic [ARC_W-1:0]  tgt_wa, res_wa, nxt_wa, tgt_ra, res_ra, nxt_ra;
   logic [NODE_W-1:0] tgt_wd, tgt_rd;
   logic [CAPACITY_WIDTH-1:0] res_wd, res_rd;
   logic [PTR_W-1:0]  nxt_wd, nxt_rd, hd_wd, hd_rd, cur_wd, cur_rd;
   logic [NODE_W-1:0] hd_wa, hd_ra, lvl_wa, lvl_ra, cur_wa, cur_ra;
   logic [NODE_W-1:0] que_wa, que_ra, que_wd, que_rd, stk_wa, stk_ra;
   logic [LEVEL_W-1:0] lvl_wd, lvl_rd;
   logic [ARC_W-1:0]  stk_wd, stk_rd;

   logic              req_fire, csr_wr;
   logic [NCNT_W-1:0] nc;
   logic [PTR_W-1:0]  hd_val, link;
   logic [ARC_W-1:0]  fa;
   logic [SUM_W:0]    flow_sum;
   logic [SUM_W+1:0]  cut_sum_next;
   logic              adm;

   dmf_ram #(.WIDTH(NODE_W), .DEPTH(ARC_DEPTH)) u_tgt (
      .clock, .wr_en(tgt_we), .wr_addr(tgt_wa), .wr_data(tgt_wd),
      .rd_addr(tgt_ra), .rd_data(tgt_rd));
   dmf_ram #(.WIDTH(CAPACITY_WIDTH), .DEPTH(ARC_DEPTH)) u_res (
      .clock, .wr_en(res_we), .wr_addr(res_wa), .wr_data(res_wd),
      .rd_addr(res_ra), .rd_data(res_rd));
   dmf_ram #(.WIDTH(PTR_W), .DEPTH(ARC_DEPTH)) u_nxt (
      .clock, .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(nxt_ra), .rd_data(nxt_rd));
   dmf_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_head (
      .clock, .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
      .rd_addr(hd_ra), .rd_data(hd_rd));
   dmf_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_NODES)) u_lvl (
      .clock, .wr_en(lvl_we), .wr_addr(lvl_wa), .wr_data(lvl_wd),
      .rd_addr(lvl_ra), .rd_data(lvl_rd));
   dmf_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_cur (
      .clock, .wr_en(cur_we), .wr_addr(cur_wa), .wr_data(cur_wd),
      .rd_addr(cur_ra), .rd_data(cur_rd));
   dmf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_que (
      .clock, .wr_en(que_we), .wr_addr(que_wa), .wr_data(que_wd),
      .rd_addr(que_ra), .rd_data(que_rd));
   dmf_ram #(.WIDTH(ARC_W), .DEPTH(MAX_NODES)) u_stk (
      .clock, .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, o_stat_ff, o_cnt_ff, o_mask_ff, o_cut_ff, o_flow_ff};

   // clamp the node count into 1 .. MAX_NODES
   always_comb begin
      priority if (node_count_ff == '0) begin
         nc = NCNT_W'(1);
      end else if (node_count_ff > NCNT_W'(MAX_NODES)) begin
         nc = NCNT_W'(MAX_NODES);
      end else begin
         nc = node_count_ff;
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_NODE_COUNT: csr_prdata = {{(32-NCNT_W){1'b0}}, node_count_ff};
         REG_SOURCE:     csr_prdata = {{(32-NODE_W){1'b0}}, src_ff};
         REG_SINK:       csr_prdata = {{(32-NODE_W){1'b0}}, snk_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign hd_val = hv_rd_ff ? hd_rd : ARC_NONE;
   assign fa     = {edge_count_ff[ARC_W-2:0], 1'b0};
   assign link   = (to_ff == from_ff) ? {1'b0, fa} : hd_val;
   assign flow_sum = {1'b0, flow_ff} + (SUM_W+1)'(b_ff);
   assign cut_sum_next = {2'b0, cut_sum_ff} + (SUM_W+2)'(r0_ff) + (SUM_W+2)'(res_rd);
   assign adm = (r_ff != '0) && reached_ff[v_ff] && (lvl_rd == lvl_u_ff + LEVEL_W'(1))
                && (depth_ff < NCNT_W'(MAX_NODES));

   always_comb begin
      node_count_in = node_count_ff;
      src_in        = src_ff;
      snk_in        = snk_ff;
      state_in      = state_ff;
      edge_count_in = edge_count_ff;
      flow_in       = flow_ff;
      ls_in         = ls_ff;
      hv_in         = hv_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      from_in = from_ff;  to_in = to_ff;  cap_in = cap_ff;  last_in = last_ff;
      status_in = status_ff;  reached_in = reached_ff;
      qh_in = qh_ff;  qt_in = qt_ff;  u_in = u_ff;  v_in = v_ff;  lvl_u_in = lvl_u_ff;
      a_in = a_ff;  n_in = n_ff;  r_in = r_ff;  b_in = b_ff;  r0_in = r0_ff;
      depth_in = depth_ff;  k_in = k_ff;  sw_in = sw_ff;  p_in = p_ff;  e_in = e_ff;
      ehead_in = ehead_ff;  cut_sum_in = cut_sum_ff;  cut_n_in = cut_n_ff;
      o_flow_in = o_flow_ff;  o_cut_in = o_cut_ff;  o_mask_in = o_mask_ff;
      o_cnt_in = o_cnt_ff;  o_stat_in = o_stat_ff;

      tgt_we = 1'b0;  tgt_wa = '0;  tgt_wd = '0;
      res_we = 1'b0;  res_wa = '0;  res_wd = '0;
      nxt_we = 1'b0;  nxt_wa = '0;  nxt_wd = '0;
      hd_we  = 1'b0;  hd_wa  = '0;  hd_wd  = '0;
      lvl_we = 1'b0;  lvl_wa = '0;  lvl_wd = '0;
      cur_we = 1'b0;  cur_wa = '0;  cur_wd = '0;
      que_we = 1'b0;  que_wa = '0;  que_wd = '0;
      stk_we = 1'b0;  stk_wa = '0;  stk_wd = '0;
      tgt_ra = '0;  res_ra = '0;  nxt_ra = '0;
      hd_ra = '0;  lvl_ra = '0;  cur_ra = '0;  que_ra = '0;  stk_ra = '0;

      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_NODE_COUNT: node_count_in = csr_pwdata[NCNT_W-1:0];
            REG_SOURCE:     src_in        = csr_pwdata[NODE_W-1:0];
            REG_SINK:       snk_in        = csr_pwdata[NODE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               from_in = req_tdata[5:0];
               to_in   = req_tdata[11:6];
               cap_in  = req_tdata[12 +: CAPACITY_WIDTH];
               last_in = req_tlast;
               priority if ({1'b0, req_tdata[5:0]} >= nc ||
                            {1'b0, req_tdata[11:6]} >= nc) begin
                  if (ls_ff == STAT_OK) ls_in = STAT_RANGE;
                  state_in = req_tlast ? ST_SOLVE : ST_IDLE;
               end else if (edge_count_ff >= ECNT_W'(MAX_EDGES)) begin
                  if (ls_ff == STAT_OK) ls_in = STAT_OVF;
                  state_in = req_tlast ? ST_SOLVE : ST_IDLE;
               end else begin
                  hd_ra    = req_tdata[5:0];
                  state_in = ST_LD1;
               end
            end
         end
         ST_LD1: begin
            // forward arc at the head of the tail node's list
            tgt_we = 1'b1;  tgt_wa = fa;  tgt_wd = to_ff;
            res_we = 1'b1;  res_wa = fa;  res_wd = cap_ff;
            nxt_we = 1'b1;  nxt_wa = fa;  nxt_wd = hd_val;
            hd_we  = 1'b1;  hd_wa  = from_ff;  hd_wd = {1'b0, fa};
            hv_in[from_ff] = 1'b1;
            hd_ra    = to_ff;
            state_in = ST_LD2;
         end
         ST_LD2: begin
            tgt_we = 1'b1;  tgt_wa = fa | ARC_W'(1);  tgt_wd = from_ff;
            res_we = 1'b1;  res_wa = fa | ARC_W'(1);  res_wd = '0;
            nxt_we = 1'b1;  nxt_wa = fa | ARC_W'(1);  nxt_wd = link;
            hd_we  = 1'b1;  hd_wa  = to_ff;  hd_wd = {1'b0, fa | ARC_W'(1)};
            hv_in[to_ff]  = 1'b1;
            edge_count_in = edge_count_ff + ECNT_W'(1);
            state_in      = last_ff ? ST_SOLVE : ST_IDLE;
         end
         ST_SOLVE: begin
            cut_sum_in = '0;
            cut_n_in   = '0;
            if ({1'b0, src_ff} >= nc || {1'b0, snk_ff} >= nc) begin
               status_in  = (ls_ff == STAT_OK) ? STAT_RANGE : ls_ff;
               reached_in = '0;
               state_in   = ST_OUT;
            end else begin
               priority if (ls_ff != STAT_OK) status_in = ls_ff;
               else if (src_ff == snk_ff)     status_in = STAT_SAME;
               else                           status_in = STAT_OK;
               state_in = ST_B_INIT;
            end
         end
         ST_B_INIT: begin
            lvl_we = 1'b1;  lvl_wa = src_ff;  lvl_wd = '0;
            que_we = 1'b1;  que_wa = '0;      que_wd = src_ff;
            reached_in = MAX_NODES'(1) << src_ff;
            qh_in    = '0;
            qt_in    = NCNT_W'(1);
            state_in = ST_B_POP;
         end
         ST_B_POP: begin
            if (qh_ff < qt_ff) begin
               que_ra   = qh_ff[NODE_W-1:0];
               qh_in    = qh_ff + NCNT_W'(1);
               state_in = ST_B_U;
            end else if (src_ff != snk_ff && reached_ff[snk_ff]) begin
               sw_in    = '0;
               state_in = ST_I_SWEEP;
            end else begin
               // sink unreachable or equal to the source: this pass is the final source side
               e_in     = '0;
               state_in = ST_C_R0;
            end
         end
         ST_B_U: begin
            u_in     = que_rd;
            lvl_ra   = que_rd;
            hd_ra    = que_rd;
            state_in = ST_B_UH;
         end
         ST_B_UH: begin
            lvl_u_in = lvl_rd;
            if (hd_val == ARC_NONE) begin
               state_in = ST_B_POP;
            end else begin
               tgt_ra = hd_val[ARC_W-1:0];  res_ra = hd_val[ARC_W-1:0];
               nxt_ra = hd_val[ARC_W-1:0];
               state_in = ST_B_ARC;
            end
         end
         ST_B_ARC: begin
            if (res_rd != '0 && !reached_ff[tgt_rd] && qt_ff < NCNT_W'(MAX_NODES)) begin
               reached_in[tgt_rd] = 1'b1;
               lvl_we = 1'b1;  lvl_wa = tgt_rd;  lvl_wd = lvl_u_ff + LEVEL_W'(1);
               que_we = 1'b1;  que_wa = qt_ff[NODE_W-1:0];  que_wd = tgt_rd;
               qt_in  = qt_ff + NCNT_W'(1);
            end
            if (nxt_rd == ARC_NONE) begin
               state_in = ST_B_POP;
            end else begin
               tgt_ra = nxt_rd[ARC_W-1:0];  res_ra = nxt_rd[ARC_W-1:0];
               nxt_ra = nxt_rd[ARC_W-1:0];
            end
         end
         ST_I_SWEEP: begin
            // copy list heads into the current-arc pointers
            if (sw_ff < NCNT_W'(MAX_NODES)) hd_ra = sw_ff[NODE_W-1:0];
            if (sw_ff != '0) begin
               cur_we = 1'b1;
               cur_wa = NODE_W'(sw_ff - NCNT_W'(1));
               cur_wd = hd_val;
            end
            sw_in = sw_ff + NCNT_W'(1);
            if (sw_ff == NCNT_W'(MAX_NODES)) begin
               depth_in = '0;
               u_in     = src_ff;
               state_in = ST_D_TOP;
            end
         end
         ST_D_TOP: begin
            if (u_ff == snk_ff) begin
               k_in     = '0;
               b_in     = '1;
               state_in = ST_A_RS;
            end else begin
               cur_ra   = u_ff;
               lvl_ra   = u_ff;
               state_in = ST_D_CUR;
            end
         end
         ST_D_CUR: begin
            lvl_u_in = lvl_rd;
            a_in     = cur_rd;
            if (cur_rd == ARC_NONE) begin
               state_in = ST_D_RET;
            end else begin
               tgt_ra = cur_rd[ARC_W-1:0];  res_ra = cur_rd[ARC_W-1:0];
               nxt_ra = cur_rd[ARC_W-1:0];
               state_in = ST_D_ARC;
            end
         end
         ST_D_ARC: begin
            v_in     = tgt_rd;
            r_in     = res_rd;
            n_in     = nxt_rd;
            lvl_ra   = tgt_rd;
            state_in = ST_D_LV;
         end
         ST_D_LV: begin
            if (adm) begin
               // advance along the arc and push it
               cur_we = 1'b1;  cur_wa = u_ff;  cur_wd = a_ff;
               stk_we = 1'b1;  stk_wa = depth_ff[NODE_W-1:0];  stk_wd = a_ff[ARC_W-1:0];
               depth_in = depth_ff + NCNT_W'(1);
               u_in     = v_ff;
               state_in = ST_D_TOP;
            end else if (n_ff == ARC_NONE) begin
               cur_we = 1'b1;  cur_wa = u_ff;  cur_wd = ARC_NONE;
               state_in = ST_D_RET;
            end else begin
               a_in   = n_ff;
               tgt_ra = n_ff[ARC_W-1:0];  res_ra = n_ff[ARC_W-1:0];
               nxt_ra = n_ff[ARC_W-1:0];
               state_in = ST_D_ARC;
            end
         end
         ST_D_RET: begin
            if (depth_ff == '0) begin
               state_in = ST_B_INIT;
            end else begin
               stk_ra   = NODE_W'(depth_ff - NCNT_W'(1));
               depth_in = depth_ff - NCNT_W'(1);
               state_in = ST_D_POP;
            end
         end
         ST_D_POP: begin
            p_in     = stk_rd;
            tgt_ra   = stk_rd ^ ARC_W'(1);
            nxt_ra   = stk_rd;
            state_in = ST_D_POP2;
         end
         ST_D_POP2: begin
            // retreat to the arc's tail and skip the dead arc
            u_in   = tgt_rd;
            cur_we = 1'b1;  cur_wa = tgt_rd;  cur_wd = nxt_rd;
            state_in = ST_D_TOP;
         end
         ST_A_RS: begin
            if (k_ff < depth_ff) begin
               stk_ra   = k_ff[NODE_W-1:0];
               state_in = ST_A_RR;
            end else begin
               k_in     = '0;
               state_in = ST_S_RS;
            end
         end
         ST_A_RR: begin
            p_in     = stk_rd;
            res_ra   = stk_rd;
            state_in = ST_A_RC;
         end
         ST_A_RC: begin
            if (res_rd < b_ff) b_in = res_rd;
            k_in     = k_ff + NCNT_W'(1);
            state_in = ST_A_RS;
         end
         ST_S_RS: begin
            if (k_ff < depth_ff) begin
               stk_ra   = k_ff[NODE_W-1:0];
               state_in = ST_S_R1;
            end else begin
               flow_in  = flow_sum[SUM_W] ? '1 : flow_sum[SUM_W-1:0];
               depth_in = '0;
               u_in     = src_ff;
               state_in = ST_D_TOP;
            end
         end
         ST_S_R1: begin
            p_in     = stk_rd;
            res_ra   = stk_rd;
            state_in = ST_S_R2;
         end
         ST_S_R2: begin
            res_we = 1'b1;  res_wa = p_ff;  res_wd = res_rd - b_ff;
            res_ra   = p_ff ^ ARC_W'(1);
            state_in = ST_S_R3;
         end
         ST_S_R3: begin
            res_we = 1'b1;  res_wa = p_ff ^ ARC_W'(1);  res_wd = res_rd + b_ff;
            k_in     = k_ff + NCNT_W'(1);
            state_in = ST_S_RS;
         end
         ST_C_R0: begin
            if (e_ff < edge_count_ff) begin
               tgt_ra = {e_ff[ARC_W-2:0], 1'b0};
               res_ra = {e_ff[ARC_W-2:0], 1'b0};
               state_in = ST_C_R1;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_C_R1: begin
            ehead_in = tgt_rd;
            r0_in    = res_rd;
            tgt_ra   = {e_ff[ARC_W-2:0], 1'b1};
            res_ra   = {e_ff[ARC_W-2:0], 1'b1};
            state_in = ST_C_R2;
         end
         ST_C_R2: begin
            if (reached_ff[tgt_rd] && !reached_ff[ehead_ff]) begin
               cut_sum_in = (cut_sum_next > (SUM_W+2)'({SUM_W{1'b1}})) ? '1
                                                         : cut_sum_next[SUM_W-1:0];
               if (cut_n_ff != '1) cut_n_in = cut_n_ff + CUTN_W'(1);
            end
            e_in     = e_ff + ECNT_W'(1);
            state_in = ST_C_R0;
         end
         ST_OUT: begin
            // hold until the output register is free, then clear the graph
            if (!rsp_valid_ff || rsp_tready) begin
               o_flow_in     = flow_ff;
               o_cut_in      = cut_sum_ff;
               o_mask_in     = reached_ff;
               o_cnt_in      = cut_n_ff;
               o_stat_in     = status_ff;
               rsp_valid_in  = 1'b1;
               hv_in         = '0;
               edge_count_in = '0;
               flow_in       = '0;
               ls_in         = STAT_OK;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      hv_rd_in = hv_ff[hd_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NCNT_W'(2);
         src_ff        <= '0;
         snk_ff        <= NODE_W'(1);
         edge_count_ff <= '0;
         flow_ff       <= '0;
         ls_ff         <= STAT_OK;
         hv_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         src_ff        <= src_in;
         snk_ff        <= snk_in;
         edge_count_ff <= edge_count_in;
         flow_ff       <= flow_in;
         ls_ff         <= ls_in;
         hv_ff         <= hv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hv_rd_ff   <= hv_rd_in;
      from_ff    <= from_in;
      to_ff      <= to_in;
      cap_ff     <= cap_in;
      last_ff    <= last_in;
      status_ff  <= status_in;
      reached_ff <= reached_in;
      qh_ff      <= qh_in;
      qt_ff      <= qt_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      lvl_u_ff   <= lvl_u_in;
      a_ff       <= a_in;
      n_ff       <= n_in;
      r_ff       <= r_in;
      b_ff       <= b_in;
      r0_ff      <= r0_in;
      depth_ff   <= depth_in;
      k_ff       <= k_in;
      sw_ff      <= sw_in;
      p_ff       <= p_in;
      e_ff       <= e_in;
      ehead_ff   <= ehead_in;
      cut_sum_ff <= cut_sum_in;
      cut_n_ff   <= cut_n_in;
      o_flow_ff  <= o_flow_in;
      o_cut_ff   <= o_cut_in;
      o_mask_ff  <= o_mask_in;
      o_cnt_ff   <= o_cnt_in;
      o_stat_ff  <= o_stat_in;
   end

endmodule

>>> verif/tb_dinic_max_flow_min_cut.sv
// ----------------------------------------------------------------------------
// tb_dinic_max_flow_min_cut
// Self-checking bench for the Dinic max-flow / min-cut engine.
// ----------------------------------------------------------------------------
// Graphs stream in as edge transfers. Each accepted edge is replayed into a
// behavioral max-flow solver kept in this bench, and the transfer with tlast
// queues the predicted result. Results are checked field by field in order.
// Registers are rewritten between graphs with the block idle. Directed graphs
// cover the corner cases; random graphs with random idling on both sides
// follow.
// ----------------------------------------------------------------------------
module tb_dinic_max_flow_min_cut;
   import dmf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NO_ARC      = -1;
   localparam int EDGE_TARGET = 1650;
   localparam int STALL_LIMIT = 4000000;
   localparam int SETTLE      = 60;

   typedef struct packed {
      logic [5:0]  from_node;
      logic [5:0]  to_node;
      logic [15:0] capacity;
      logic        last_edge;
   } edge_type;

   typedef struct packed {
      logic [23:0] flow_val;
      logic [23:0] cut_capacity;
      logic [63:0] side_mask;
      logic [8:0]  cut_cnt;
      logic [1:0]  status;
   } cut_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   dinic_max_flow_min_cut dut (.*);

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Solver shadow: registers and graph state
   // ---------------------------------------------------------------------
   logic [6:0] cfg_nodes = 7'd2;
   logic [5:0] cfg_src = 6'd0;
   logic [5:0] cfg_snk = 6'd1;

   logic [5:0]  arc_to [ARC_DEPTH];
   int unsigned arc_res [ARC_DEPTH];
   int          arc_link [ARC_DEPTH];
   int          list_head [MAX_NODES];
   int          lvl [MAX_NODES];
   int          cur_arc [MAX_NODES];
   int          path [MAX_NODES];
   int          stored_edges;
   logic [1:0]  load_err;

   edge_type pending_edges[$];
   cut_type  expected_cuts[$];
   int    errors = 0;
   int    edges_sent = 0;
   int    req_max_gap = 12;
   int    rsp_max_gap = 12;

   function automatic void clear_graph();
      for (int n = 0; n < MAX_NODES; n++) list_head[n] = NO_ARC;
      stored_edges = 0;
      load_err = STAT_OK;
   endfunction

   function automatic int unsigned live_nodes();
      int unsigned nc;
      nc = cfg_nodes;
      if (nc == 0) nc = 1;
      if (nc > MAX_NODES) nc = MAX_NODES;
      return nc;
   endfunction

   function automatic int live_nodes_of(int nodes);
      int n;
      n = nodes & 127;
      if (n == 0) n = 1;
      if (n > MAX_NODES) n = MAX_NODES;
      return n;
   endfunction

   // breadth-first levels over arcs with residual left
   function automatic logic [63:0] level_sweep(int src);
      logic [63:0] seen;
      int q [MAX_NODES];
      int qh, qt, u, a, v;
      seen = 64'd1 << src;
      qh = 0;
      qt = 1;
      q[0] = src;
      lvl[src] = 0;
      while (qh < qt) begin
         u = q[qh];
         qh++;
         a = list_head[u];
         while (a != NO_ARC) begin
            v = arc_to[a];
            if (arc_res[a] > 0 && !seen[v] && qt < MAX_NODES) begin
               seen[v] = 1'b1;
               lvl[v] = lvl[u] + 1;
               q[qt] = v;
               qt++;
            end
            a = arc_link[a];
         end
      end
      return seen;
   endfunction

   // push one blocking flow through the level graph with current-arc pointers
   function automatic longint unsigned blocking_push(int src, int snk,
                                                      logic [63:0] seen);
      longint unsigned total;
      int unsigned b;
      int depth, u, a, p;
      total = 0;
      depth = 0;
      u = src;
      for (int n = 0; n < MAX_NODES; n++) cur_arc[n] = list_head[n];
      while (1) begin
         if (u == snk) begin
            b = 32'hFFFF_FFFF;
            for (int k = 0; k < depth; k++)
               if (arc_res[path[k]] < b) b = arc_res[path[k]];
            for (int k = 0; k < depth; k++) begin
               arc_res[path[k]] -= b;
               arc_res[path[k] ^ 1] += b;
            end
            total += b;
            depth = 0;
            u = src;
         end else begin
            a = cur_arc[u];
            while (a != NO_ARC && !(arc_res[a] > 0 && seen[arc_to[a]] &&
                   lvl[arc_to[a]] == lvl[u] + 1 && depth < MAX_NODES))
               a = arc_link[a];
            cur_arc[u] = a;
            if (a != NO_ARC) begin
               path[depth] = a;
               depth++;
               u = arc_to[a];
            end else begin
               if (depth == 0) return total;
               depth--;
               p = path[depth];
               u = arc_to[p ^ 1];
               cur_arc[u] = arc_link[p];
            end
         end
      end
      return total;
   endfunction

   // store one edge; on the last edge solve and queue the expected cut
   function automatic void apply_edge(edge_type e);
      int unsigned nc;
      int fa, src, snk;
      longint unsigned flow, cut_sum;
      int unsigned cut_n;
      logic [63:0] seen;
      cut_type r;
      nc = live_nodes();
      src = cfg_src;
      snk = cfg_snk;
      flow = 0;
      cut_sum = 0;
      cut_n = 0;
      if (e.from_node >= nc || e.to_node >= nc) begin
         if (load_err == STAT_OK) load_err = STAT_RANGE;
      end else if (stored_edges >= MAX_EDGES) begin
         if (load_err == STAT_OK) load_err = STAT_OVF;
      end else begin
         fa = 2 * stored_edges;
         arc_to[fa] = e.to_node;
         arc_res[fa] = e.capacity;
         arc_link[fa] = list_head[e.from_node];
         list_head[e.from_node] = fa;
         arc_to[fa+1] = e.from_node;
         arc_res[fa+1] = 0;
         arc_link[fa+1] = list_head[e.to_node];
         list_head[e.to_node] = fa + 1;
         stored_edges++;
      end
      if (!e.last_edge) return;
      r = '0;
      r.status = load_err;
      if (src >= nc || snk >= nc) begin
         if (r.status == STAT_OK) r.status = STAT_RANGE;
      end else begin
         if (r.status == STAT_OK && src == snk) r.status = STAT_SAME;
         if (src != snk) begin
            seen = level_sweep(src);
            while (seen[snk]) begin
               flow += blocking_push(src, snk, seen);
               seen = level_sweep(src);
            end
         end
         seen = level_sweep(src);
         for (int k = 0; k < stored_edges; k++)
            if (seen[arc_to[2*k+1]] && !seen[arc_to[2*k]]) begin
               cut_sum += arc_res[2*k] + arc_res[2*k+1];
               cut_n++;
            end
         r.flow_val = flow > 64'hFF_FFFF ? 24'hFF_FFFF : flow[23:0];
         r.cut_capacity = cut_sum > 64'hFF_FFFF ? 24'hFF_FFFF : cut_sum[23:0];
         r.side_mask = seen;
         r.cut_cnt = cut_n > 511 ? 9'h1FF : cut_n[8:0];
      end
      expected_cuts.insert(expected_cuts.size(), r);
      clear_graph();
   endfunction

   // ---------------------------------------------------------------------
   // Edge driver: change at falling edge, hold until the transfer
   // ---------------------------------------------------------------------
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   int   req_wait = 0;
   int   rsp_wait = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_took) begin
         // hold the offered edge
      end else if (req_wait > 0) begin
         req_tvalid <= 1'b0;
         req_wait <= req_wait - 1;
      end else if (pending_edges.size() > 0) begin
         edge_type e;
         e = pending_edges.pop_front();
         req_tdata <= {4'b0, e.capacity, e.to_node, e.from_node};
         req_tlast <= e.last_edge;
         req_tvalid <= 1'b1;
         req_wait <= $urandom_range(0, req_max_gap);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result side: stall a random number of cycles before each transfer
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_took) begin
         rsp_tready <= 1'b0;
         rsp_wait <= $urandom_range(0, rsp_max_gap);
      end else if (rsp_wait > 0) begin
         rsp_tready <= 1'b0;
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on edge transfers, check on result transfers
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      edge_type e;
      cut_type  got;
      cut_type  want;
      req_took <= req_tvalid && req_tready && !reset;
      rsp_took <= rsp_tvalid && rsp_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         e.from_node = req_tdata[5:0];
         e.to_node = req_tdata[11:6];
         e.capacity = req_tdata[27:12];
         e.last_edge = req_tlast;
         apply_edge(e);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.flow_val = rsp_tdata[23:0];
         got.cut_capacity = rsp_tdata[47:24];
         got.side_mask = rsp_tdata[111:48];
         got.cut_cnt = rsp_tdata[120:112];
         got.status = rsp_tdata[122:121];
         if (expected_cuts.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: %h", $realtime, got);
         end else begin
            want = expected_cuts.pop_front();
            if (got.flow_val !== want.flow_val) begin
               errors++;
               $display("%0t: total flow expected %0d got %0d", $realtime,
                        want.flow_val, got.flow_val);
            end
            if (got.cut_capacity !== want.cut_capacity) begin
               errors++;
               $display("%0t: cut_capacity expected %0d got %0d", $realtime,
                        want.cut_capacity, got.cut_capacity);
            end
            if (got.side_mask !== want.side_mask) begin
               errors++;
               $display("%0t: source_side_mask expected %h got %h", $realtime,
                        want.side_mask, got.side_mask);
            end
            if (got.cut_cnt !== want.cut_cnt) begin
               errors++;
               $display("%0t: cut_edge_count expected %0d got %0d", $realtime,
                        want.cut_cnt, got.cut_cnt);
            end
            if (got.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d got %0d", $realtime,
                        want.status, got.status);
            end
         end
      end
      // watchdog: count cycles with no transfer on either stream
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_dinic_max_flow_min_cut failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      // mirror the register as the block latches it
      case (idx)
         REG_NODE_COUNT: cfg_nodes = value[6:0];
         REG_SOURCE:     cfg_src = value[5:0];
         REG_SINK:       cfg_snk = value[5:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(int nodes, int src, int snk);
      csr_write(REG_NODE_COUNT, nodes);
      csr_write(REG_SOURCE, src);
      csr_write(REG_SINK, snk);
   endtask

   // wait until every edge is taken and every result is back, then settle
   task automatic wait_idle();
      while (pending_edges.size() > 0 || req_tvalid || expected_cuts.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic queue_edge(int f, int t, int cap, bit last);
      edge_type e;
      e.from_node = f;
      e.to_node = t;
      e.capacity = cap;
      e.last_edge = last;
      pending_edges.insert(pending_edges.size(), e);
      edges_sent++;
   endtask

   // random graph; noise picks endpoints over the whole index range
   task automatic random_graph(int n_edges, int noise_pct);
      int nc, f, t, cap;
      nc = live_nodes();
      for (int k = 0; k < n_edges; k++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            f = $urandom_range(0, 63);
            t = $urandom_range(0, 63);
         end else begin
            f = $urandom_range(0, 3) == 0 ? cfg_src % nc : $urandom_range(0, nc - 1);
            t = $urandom_range(0, 3) == 0 ? cfg_snk % nc : $urandom_range(0, nc - 1);
         end
         case ($urandom_range(0, 5))
            0: cap = 0;
            1: cap = 16'hFFFF;
            2, 3: cap = $urandom_range(1, 20);
            default: cap = $urandom_range(0, 16'hFFFF);
         endcase
         queue_edge(f, t, cap, k == n_edges - 1);
      end
   endtask

   initial begin
      int nodes, src, snk;
      clear_graph();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset registers, one full-capacity edge
      queue_edge(0, 1, 16'hFFFF, 1);
      wait_idle();
      // diamond with a zero-capacity arc
      set_regs(4, 0, 3);
      queue_edge(0, 1, 0, 0);
      queue_edge(1, 3, 5, 0);
      queue_edge(0, 2, 7, 0);
      queue_edge(2, 3, 3, 1);
      // endpoint out of range, then a good edge
      queue_edge(0, 5, 9, 0);
      queue_edge(0, 3, 4, 1);
      wait_idle();
      // source equal to sink
      set_regs(4, 0, 0);
      queue_edge(0, 1, 4, 0);
      queue_edge(1, 0, 2, 1);
      wait_idle();
      // node count zero counts as one; sink then out of range
      set_regs(0, 0, 1);
      queue_edge(0, 0, 6, 1);
      wait_idle();
      // oversized node count clamps to the maximum; top indices
      set_regs(127, 63, 0);
      queue_edge(63, 62, 16'hFFFF, 0);
      queue_edge(62, 0, 16'hFFFF, 0);
      queue_edge(63, 0, 1, 1);
      wait_idle();
      // node count shrinks while edges are loaded
      set_regs(8, 0, 7);
      queue_edge(0, 7, 9, 0);
      queue_edge(0, 5, 2, 0);
      queue_edge(5, 2, 2, 0);
      wait_idle();
      set_regs(3, 0, 2);
      queue_edge(0, 2, 3, 1);
      wait_idle();

      // random graphs; a few overflow the edge store
      while (edges_sent < EDGE_TARGET) begin
         case ($urandom_range(0, 9))
            0: nodes = 64;
            1: nodes = $urandom_range(0, 127);
            default: nodes = $urandom_range(2, 12);
         endcase
         src = $urandom_range(0, 15) == 0 ? $urandom_range(0, 63)
                                          : $urandom_range(0, 63) % live_nodes_of(nodes);
         snk = $urandom_range(0, 15) == 0 ? $urandom_range(0, 63)
                                          : $urandom_range(0, 63) % live_nodes_of(nodes);
         set_regs(nodes, src, snk);
         req_max_gap = $urandom_range(0, 2) == 0 ? 0 : 12;
         rsp_max_gap = $urandom_range(0, 2) == 0 ? 0 : 12;
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 59) == 0)
               random_graph($urandom_range(257, 266), 2);
            else
               random_graph($urandom_range(1, 24), $urandom_range(0, 3) == 0 ? 10 : 0);
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("tb_dinic_max_flow_min_cut passed");
      end else begin
         $display("tb_dinic_max_flow_min_cut failed");
      end
      $finish;
   end

endmodule

>>> dinic_max_flow_min_cut.f
hdl/dmf_pkg.sv
hdl/dmf_ram.sv
hdl/dinic_max_flow_min_cut.sv
verif/tb_dinic_max_flow_min_cut.sv
